[rtl/gsfc_pkg.sv]
package gsfc_pkg;

   // Result kinds reported on the response channel.
   typedef enum logic [2:0] {
      KIND_TX_BYTE  = 3'd0,
      KIND_RX_TAKEN = 3'd1,
      KIND_RX_IGNORED = 3'd2,
      KIND_FRAME_GOOD = 3'd3,
      KIND_FRAME_BAD  = 3'd4
   } kind_type;

   // Request types on the input channel.
   localparam logic REQ_SEND = 1'b0;
   localparam logic REQ_RECV = 1'b1;

   // Frame constants.
   localparam logic [7:0] HDR_BYTE    = 8'hFF;
   localparam logic [7:0] ADDR_BYTE   = 8'h01;
   localparam logic [7:0] CMD_READ    = 8'h86;
   localparam logic [7:0] CMD_MODE    = 8'h78;
   localparam logic [7:0] CMD_DORMANT = 8'hA7;
   localparam logic [7:0] CMD_SPAN    = 8'h88;

   localparam int FRAME_LEN = 9;
   localparam int PAYLOAD_LEN = 6;

   typedef logic [3:0] count_type;
   localparam count_type LAST_BYTE_IDX = count_type'(FRAME_LEN - 1);
   localparam count_type FRAME_DONE    = count_type'(FRAME_LEN);

endpackage

[rtl/gas_sensor_frame_codec_top.sv]
// Framer and deframer for a nine-byte UART gas-sensor link.
// Input channel (req_): one transaction is either a send request (req_type 0),
// which carries the command code and argument, or one byte received from the
// sensor (req_type 1). Response channel (rsp_): each transaction is one result.
// A send request yields nine results, the command frame bytes in order, with
// rsp_last on the checksum byte; it also restarts the reply receiver.
// A received byte yields one result: taken, ignored (after a complete reply),
// or, on the ninth reply byte, frame good or bad with reply bytes 2..7.
// The first result of a transaction is presented on the cycle after acceptance.
// Received bytes are taken one per cycle unless a result is stalled. A send
// request holds the input channel while its frame bytes are driven from the
// output register; the next transaction is accepted as the checksum byte goes out.
// A single output register separates the channels: a new transaction is taken
// while the register is empty or its result is being taken in the same cycle.
// When the receiver asserts rsp_stall on a valid result, the result holds and req_stall rises.
// Reset (synchronous) empties the output register, stops any frame in flight
// and clears the receiver state.
module gas_sensor_frame_codec_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_type,
   input  logic [7:0] req_command_code,
   input  logic [15:0] req_argument,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_last,
   output logic [7:0] rsp_payload0,
   output logic [7:0] rsp_payload1,
   output logic [7:0] rsp_payload2,
   output logic [7:0] rsp_payload3,
   output logic [7:0] rsp_payload4,
   output logic [7:0] rsp_payload5
);
   import gsfc_pkg::*;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   kind_type   rsp_kind_ff, rsp_kind_in;
   logic [7:0] rsp_tx_byte_ff, rsp_tx_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic [7:0] rsp_payload_ff [PAYLOAD_LEN];
   logic [7:0] rsp_payload_in [PAYLOAD_LEN];

   // Transmit frame in flight.
   logic       tx_busy_ff, tx_busy_in;
   count_type  tx_idx_ff, tx_idx_in;
   logic [7:0] tx_cmd_ff, tx_cmd_in;
   logic [7:0] tx_b3_ff, tx_b3_in;
   logic [7:0] tx_b4_ff, tx_b4_in;
   logic [7:0] tx_chk_ff, tx_chk_in;

   // Reply receiver.
   count_type  rx_count_ff, rx_count_in;
   logic [7:0] rx_sum_ff, rx_sum_in;
   logic       header_ok_ff, header_ok_in;
   logic       reply_code_ok_ff, reply_code_ok_in;
   logic [7:0] payload_store_ff [PAYLOAD_LEN];
   logic [7:0] payload_store_in [PAYLOAD_LEN];

   logic       out_load;
   logic       accept;
   logic [7:0] arg_b3, arg_b4, frame_sum, tx_sel_byte;
   logic [2:0] store_idx;
   logic       frame_good;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = tx_busy_ff || !out_load;
   assign accept    = req_valid && !req_stall;

   // Bytes 3 and 4 of the command frame depend on the command.
   always_comb begin
      arg_b3 = 8'h00;
      arg_b4 = 8'h00;
      if (req_command_code == CMD_SPAN) begin
         arg_b3 = req_argument[15:8];
         arg_b4 = req_argument[7:0];
      end else if (req_command_code == CMD_MODE || req_command_code == CMD_DORMANT) begin
         arg_b3 = req_argument[7:0];
      end
   end

   assign frame_sum = ADDR_BYTE + req_command_code + arg_b3 + arg_b4;

   always_comb begin
      case (tx_idx_ff)
         4'd0:    tx_sel_byte = HDR_BYTE;
         4'd1:    tx_sel_byte = ADDR_BYTE;
         4'd2:    tx_sel_byte = tx_cmd_ff;
         4'd3:    tx_sel_byte = tx_b3_ff;
         4'd4:    tx_sel_byte = tx_b4_ff;
         4'd8:    tx_sel_byte = tx_chk_ff;
         default: tx_sel_byte = 8'h00;
      endcase
   end

   assign store_idx  = rx_count_ff[2:0] - 3'd2;
   assign frame_good = header_ok_ff && reply_code_ok_ff &&
                       (8'(8'h00 - rx_sum_ff) == req_rx_byte);

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_kind_in      = rsp_kind_ff;
      rsp_tx_byte_in   = rsp_tx_byte_ff;
      rsp_last_in      = rsp_last_ff;
      rsp_payload_in   = rsp_payload_ff;
      tx_busy_in       = tx_busy_ff;
      tx_idx_in        = tx_idx_ff;
      tx_cmd_in        = tx_cmd_ff;
      tx_b3_in         = tx_b3_ff;
      tx_b4_in         = tx_b4_ff;
      tx_chk_in        = tx_chk_ff;
      rx_count_in      = rx_count_ff;
      rx_sum_in        = rx_sum_ff;
      header_ok_in     = header_ok_ff;
      reply_code_ok_in = reply_code_ok_ff;
      payload_store_in = payload_store_ff;

      if (out_load) begin
         rsp_valid_in = 1'b0;
      end

      if (accept && req_type == REQ_SEND) begin
         // Header byte goes out now; the rest follow from the frame registers.
         rsp_valid_in     = 1'b1;
         rsp_kind_in      = KIND_TX_BYTE;
         rsp_tx_byte_in   = HDR_BYTE;
         rsp_last_in      = 1'b0;
         for (int i = 0; i < PAYLOAD_LEN; i++) rsp_payload_in[i] = 8'h00;
         tx_busy_in       = 1'b1;
         tx_idx_in        = 4'd1;
         tx_cmd_in        = req_command_code;
         tx_b3_in         = arg_b3;
         tx_b4_in         = arg_b4;
         tx_chk_in        = 8'h00 - frame_sum;
         rx_count_in      = '0;
         rx_sum_in        = 8'h00;
         header_ok_in     = 1'b0;
         reply_code_ok_in = 1'b0;
      end else if (accept) begin
         rsp_valid_in   = 1'b1;
         rsp_tx_byte_in = 8'h00;
         rsp_last_in    = 1'b0;
         for (int i = 0; i < PAYLOAD_LEN; i++) rsp_payload_in[i] = 8'h00;
         if (rx_count_ff >= FRAME_DONE) begin
            rsp_kind_in = KIND_RX_IGNORED;
         end else if (rx_count_ff == '0) begin
            header_ok_in = (req_rx_byte == HDR_BYTE);
            rx_count_in  = rx_count_ff + 4'd1;
            rsp_kind_in  = KIND_RX_TAKEN;
         end else if (rx_count_ff < LAST_BYTE_IDX) begin
            rx_sum_in = rx_sum_ff + req_rx_byte;
            if (rx_count_ff == 4'd1) begin
               reply_code_ok_in = (req_rx_byte == CMD_READ || req_rx_byte == CMD_MODE ||
                                   req_rx_byte == CMD_DORMANT);
            end else begin
               for (int i = 0; i < PAYLOAD_LEN; i++) begin
                  if (store_idx == 3'(i)) payload_store_in[i] = req_rx_byte;
               end
            end
            rx_count_in = rx_count_ff + 4'd1;
            rsp_kind_in = KIND_RX_TAKEN;
         end else begin
            rx_count_in    = FRAME_DONE;
            rsp_kind_in    = frame_good ? KIND_FRAME_GOOD : KIND_FRAME_BAD;
            rsp_payload_in = payload_store_ff;
         end
      end else if (tx_busy_ff && out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = KIND_TX_BYTE;
         rsp_tx_byte_in = tx_sel_byte;
         rsp_last_in    = (tx_idx_ff == LAST_BYTE_IDX);
         for (int i = 0; i < PAYLOAD_LEN; i++) rsp_payload_in[i] = 8'h00;
         tx_idx_in      = tx_idx_ff + 4'd1;
         if (tx_idx_ff == LAST_BYTE_IDX) begin
            tx_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         tx_busy_ff       <= 1'b0;
         tx_idx_ff        <= '0;
         rx_count_ff      <= '0;
         rx_sum_ff        <= 8'h00;
         header_ok_ff     <= 1'b0;
         reply_code_ok_ff <= 1'b0;
      end else begin
         rsp_valid_ff     <= rsp_valid_in;
         tx_busy_ff       <= tx_busy_in;
         tx_idx_ff        <= tx_idx_in;
         rx_count_ff      <= rx_count_in;
         rx_sum_ff        <= rx_sum_in;
         header_ok_ff     <= header_ok_in;
         reply_code_ok_ff <= reply_code_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff      <= rsp_kind_in;
      rsp_tx_byte_ff   <= rsp_tx_byte_in;
      rsp_last_ff      <= rsp_last_in;
      rsp_payload_ff   <= rsp_payload_in;
      tx_cmd_ff        <= tx_cmd_in;
      tx_b3_ff         <= tx_b3_in;
      tx_b4_ff         <= tx_b4_in;
      tx_chk_ff        <= tx_chk_in;
      payload_store_ff <= payload_store_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_tx_byte  = rsp_tx_byte_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_payload0 = rsp_payload_ff[0];
   assign rsp_payload1 = rsp_payload_ff[1];
   assign rsp_payload2 = rsp_payload_ff[2];
   assign rsp_payload3 = rsp_payload_ff[3];
   assign rsp_payload4 = rsp_payload_ff[4];
   assign rsp_payload5 = rsp_payload_ff[5];

   // A frame in flight blocks the input channel.
   assert property (@(posedge clock) disable iff (reset) tx_busy_ff |-> req_stall)
      else $error("input accepted while a command frame is being sent");

   // Only the checksum byte of a command frame carries the last flag.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_kind_ff == KIND_TX_BYTE && !tx_busy_ff))
      else $error("last flag on a result that does not end a frame");

   // An accepted send request starts a frame with the header byte.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_type == REQ_SEND) |=>
      (rsp_valid_ff && tx_busy_ff && rsp_tx_byte_ff == HDR_BYTE && rx_count_ff == '0))
      else $error("send request did not start a frame");

   // The receiver never counts past a complete reply.
   assert property (@(posedge clock) disable iff (reset) rx_count_ff <= FRAME_DONE)
      else $error("reply byte count out of range");

endmodule
